>>> rtl/sal_pkg.sv
// Shared constants and types for the sorted array list.
`default_nettype none
package sal_pkg;

  // Capacity of the list and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W   = 32;
  localparam int CMD_W   = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REWIND = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

  // Control broadcast to every cell
  typedef struct packed {
    logic             ins;    // insert accepted, list not full
    logic             del;    // delete accepted
    logic             found;  // some valid cell matches the key
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/sorted_array_list.sv
// Top level of the sorted array list: command decode, count, cursor, cell row.
//
//   channel   handshake           payload
//   command   start / busy        cmd, key
//   result    done (one cycle)    ok, key_out, length, full_res
//
// A command word is taken on any cycle with start high; busy stays low.
// Its result shows on done in the following cycle, for exactly that cycle.
// All cells compare and shift in parallel, so no command stalls the next one.
// rst (synchronous) empties the list and zeroes the cursor; stored keys
// are not cleared. The receiver cannot stall the result.
`default_nettype none
module sorted_array_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sal_pkg::CMD_W-1:0]   cmd,
  input  wire logic [sal_pkg::KEY_W-1:0]   key,
  output logic                             done,
  output logic                             ok,
  output logic      [sal_pkg::KEY_W-1:0]   key_out,
  output logic      [sal_pkg::COUNT_W-1:0] length,
  output logic                             full_res
);

  localparam int DEPTH   = sal_pkg::DEPTH;
  localparam int COUNT_W = sal_pkg::COUNT_W;
  localparam int KEY_W   = sal_pkg::KEY_W;
  localparam int IDX_W   = sal_pkg::IDX_W;

  logic [COUNT_W-1:0]  count, count_next;
  logic [COUNT_W-1:0]  cursor, cursor_next;
  logic [KEY_W-1:0]    ent [DEPTH];
  logic [DEPTH-1:0]    ge_vec, eq_vec, valid_vec;
  logic                found, is_full, cursor_ok;
  logic                ok_next;
  logic [KEY_W-1:0]    key_out_next;
  sal_pkg::cell_ctrl_t ctrl;

  assign busy    = 1'b0;
  assign found   = |eq_vec;
  assign is_full = (count == COUNT_W'(DEPTH));
  assign cursor_ok = (cursor < count);

  // Broadcast control to the cells
  always_comb begin
    ctrl.ins   = start && (cmd == sal_pkg::CMD_INSERT) && !is_full;
    ctrl.del   = start && (cmd == sal_pkg::CMD_DELETE);
    ctrl.found = found;
    ctrl.key   = key;
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             lv, lg;
    logic [KEY_W-1:0] le, re;

    assign valid_vec[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign le = '0;
    end else begin : g_mid
      assign lv = valid_vec[i-1];
      assign lg = ge_vec[i-1];
      assign le = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign re = ent[i];
    end else begin : g_inner
      assign re = ent[i+1];
    end

    sal_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid_vec[i]),
      .left_valid  (lv),
      .left_ge     (lg),
      .left_entry  (le),
      .right_entry (re),
      .entry       (ent[i]),
      .ge          (ge_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  // Command decode: next count, cursor and result
  always_comb begin
    count_next   = count;
    cursor_next  = cursor;
    ok_next      = 1'b0;
    key_out_next = key;
    case (cmd)
      sal_pkg::CMD_INSERT: begin
        if (!is_full) begin
          count_next = count + 1'b1;
          ok_next    = 1'b1;
        end
      end
      sal_pkg::CMD_DELETE: begin
        if (found) begin
          count_next = count - 1'b1;
          ok_next    = 1'b1;
        end
      end
      sal_pkg::CMD_LOOKUP: begin
        ok_next = found;
      end
      sal_pkg::CMD_CLEAR: begin
        count_next = '0;
        ok_next    = 1'b1;
      end
      sal_pkg::CMD_REWIND: begin
        cursor_next = '0;
        ok_next     = 1'b1;
      end
      sal_pkg::CMD_NEXT: begin
        if (cursor_ok) begin
          key_out_next = ent[cursor[IDX_W-1:0]];
          cursor_next  = cursor + 1'b1;
          ok_next      = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
      done   <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (start) begin
      ok       <= ok_next;
      key_out  <= key_out_next;
      length   <= count_next;
      full_res <= (count_next == COUNT_W'(DEPTH));
    end
  end

endmodule
`default_nettype wire

>>> rtl/sal_cell.sv
// One slot of the sorted list: holds an entry and shifts with its neighbors.
`default_nettype none
module sal_cell (
  input  wire logic                      clk,
  input  wire sal_pkg::cell_ctrl_t       ctrl,
  input  wire logic                      valid,
  input  wire logic                      left_valid,
  input  wire logic                      left_ge,
  input  wire logic [sal_pkg::KEY_W-1:0] left_entry,
  input  wire logic [sal_pkg::KEY_W-1:0] right_entry,
  output logic      [sal_pkg::KEY_W-1:0] entry,
  output logic                           ge,
  output logic                           eq
);

  // Compare flags for this slot
  assign ge = valid && (entry >= ctrl.key);
  assign eq = valid && (entry == ctrl.key);

  // Insert: slots past the lower bound take the left entry, the bound takes the key.
  // Delete: slots from the first match on take the right entry.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_ge) begin
        entry <= left_entry;
      end else if (ge || (!valid && left_valid)) begin
        entry <= ctrl.key;
      end
    end else if (ctrl.del && ctrl.found && ge) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire
